// ===== sv/triangle_bbox_area_accumulator_assert.svh =====
// ----------------------------------------------------------------------------
// Triangle bbox/area accumulator assertion macros
// Shared property shapes for the port checker.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_BBOX_AREA_ACCUMULATOR_ASSERT_SVH
`define TRIANGLE_BBOX_AREA_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication.
`define TBBA_ASSERT_IMP(label, clk, dis, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (a) |-> (b)) else $error(msg);

// Next-cycle implication.
`define TBBA_ASSERT_NEXT(label, clk, dis, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (a) |=> (b)) else $error(msg);

`endif

// ===== sv/tbba_pkg.sv =====
// ----------------------------------------------------------------------------
// tbba_pkg
// Types, widths and helpers for the triangle bbox/area accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package tbba_pkg;

  localparam int COORD_BITS = 24;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int COUNT_BITS = 32;
  localparam int MUL_BITS   = 26;
  localparam int PROD_BITS  = 2 * MUL_BITS;
  localparam int MAG_BITS   = 50;
  localparam int HALF_BITS  = MAG_BITS / 2;
  localparam int ACC_BITS   = 2 * MAG_BITS;
  localparam int ROOT_BITS  = MAG_BITS;
  localparam int REM_BITS   = ROOT_BITS + 2;
  localparam int AREA_BITS  = 64;
  localparam int STEP_LAST  = 15;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic [COUNT_BITS-1:0]        count_t;
  typedef logic [AREA_BITS-1:0]         area_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by;
    coord_t bz;
    coord_t cxin;
    coord_t cyin;
    coord_t czin;
    logic   start_mesh;
  } in_word_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
    area_t  area_sum;
    count_t triangle_count;
  } out_word_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
    count_t count;
    logic   restart;
    diff_t  ab_x;
    diff_t  ab_y;
    diff_t  ab_z;
    diff_t  ac_x;
    diff_t  ac_y;
    diff_t  ac_z;
  } job_t;

  function automatic coord_t cmin(input coord_t a, input coord_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic coord_t cmax(input coord_t a, input coord_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// ===== sv/triangle_bbox_area_accumulator.sv =====
// ----------------------------------------------------------------------------
// triangle_bbox_area_accumulator
// Running bounding box, doubled surface area and triangle count of a mesh.
//
//   port group            dir   word          handshake
//   push/full/data_in     in    in_word_t     push & !full
//   empty/pop/data_out    out   out_word_t    pop & !empty
//
// The front forms box, count and edge vectors in the accept cycle. With an idle
// engine a result leaves the queue, passes through the shared 26x26 multiplier
// and the bit-serial square root, and is loaded into the result register. The
// engine takes no new word until its last result is in the result register.
// Reset (rst, synchronous) empties the queue and result register and clears
// the totals. An unpopped result holds the engine; full rises at two queued words.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_bbox_area_accumulator (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire tbba_pkg::in_word_t  data_in,
  output logic                     empty,
  input  wire logic                pop,
  output tbba_pkg::out_word_t      data_out
);

  tbba_pkg::job_t f_job;
  tbba_pkg::job_t q_job;
  logic           q_empty;
  logic           q_pop;

  tbba_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .data_in (data_in),
    .q_full  (full),
    .job     (f_job)
  );

  tbba_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (f_job),
    .full   (full),
    .pop    (q_pop),
    .rd_job (q_job),
    .empty  (q_empty)
  );

  tbba_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_job    (q_job),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .data_out (data_out)
  );

endmodule

`default_nettype wire

// ===== sv/tbba_front.sv =====
// ----------------------------------------------------------------------------
// tbba_front
// Accepts triangles, tracks the bounding box and count, forms edge vectors.
// ----------------------------------------------------------------------------
`default_nettype none

module tbba_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire tbba_pkg::in_word_t data_in,
  input  wire logic             q_full,
  output tbba_pkg::job_t        job
);

  tbba_pkg::coord_t min_x, min_y, min_z, max_x, max_y, max_z;
  tbba_pkg::count_t tally;
  tbba_pkg::count_t base_tally;
  logic             seed;

  assign base_tally = data_in.start_mesh ? '0 : tally;
  assign seed       = (base_tally == '0);

  always_comb begin
    job.restart = data_in.start_mesh;
    job.count   = (base_tally == '1) ? base_tally : base_tally + 1'b1;
    job.min_x = tbba_pkg::cmin(tbba_pkg::cmin(tbba_pkg::cmin(seed ? data_in.ax : min_x,
                data_in.ax), data_in.bx), data_in.cxin);
    job.min_y = tbba_pkg::cmin(tbba_pkg::cmin(tbba_pkg::cmin(seed ? data_in.ay : min_y,
                data_in.ay), data_in.by), data_in.cyin);
    job.min_z = tbba_pkg::cmin(tbba_pkg::cmin(tbba_pkg::cmin(seed ? data_in.az : min_z,
                data_in.az), data_in.bz), data_in.czin);
    job.max_x = tbba_pkg::cmax(tbba_pkg::cmax(tbba_pkg::cmax(seed ? data_in.ax : max_x,
                data_in.ax), data_in.bx), data_in.cxin);
    job.max_y = tbba_pkg::cmax(tbba_pkg::cmax(tbba_pkg::cmax(seed ? data_in.ay : max_y,
                data_in.ay), data_in.by), data_in.cyin);
    job.max_z = tbba_pkg::cmax(tbba_pkg::cmax(tbba_pkg::cmax(seed ? data_in.az : max_z,
                data_in.az), data_in.bz), data_in.czin);
    job.ab_x = tbba_pkg::diff_t'(data_in.bx) - tbba_pkg::diff_t'(data_in.ax);
    job.ab_y = tbba_pkg::diff_t'(data_in.by) - tbba_pkg::diff_t'(data_in.ay);
    job.ab_z = tbba_pkg::diff_t'(data_in.bz) - tbba_pkg::diff_t'(data_in.az);
    job.ac_x = tbba_pkg::diff_t'(data_in.cxin) - tbba_pkg::diff_t'(data_in.ax);
    job.ac_y = tbba_pkg::diff_t'(data_in.cyin) - tbba_pkg::diff_t'(data_in.ay);
    job.ac_z = tbba_pkg::diff_t'(data_in.czin) - tbba_pkg::diff_t'(data_in.az);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tally <= '0;
      min_x <= '0;
      min_y <= '0;
      min_z <= '0;
      max_x <= '0;
      max_y <= '0;
      max_z <= '0;
    end else if (push && !q_full) begin
      tally <= job.count;
      min_x <= job.min_x;
      min_y <= job.min_y;
      min_z <= job.min_z;
      max_x <= job.max_x;
      max_y <= job.max_y;
      max_z <= job.max_z;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tbba_queue.sv =====
// ----------------------------------------------------------------------------
// tbba_queue
// Two-entry job queue between the front and the area engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tbba_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tbba_pkg::job_t wr_job,
  output logic                full,
  input  wire logic           pop,
  output tbba_pkg::job_t      rd_job,
  output logic                empty
);

  tbba_pkg::job_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     cnt;
  logic           do_push;
  logic           do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

// ===== sv/tbba_back.sv =====
// ----------------------------------------------------------------------------
// tbba_back
// Area engine: cross product through one shared multiplier, bit-serial
// square root, saturating area sum and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tbba_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tbba_pkg::job_t q_job,
  input  wire logic           q_empty,
  output logic                q_pop,
  output logic                empty,
  input  wire logic           pop,
  output tbba_pkg::out_word_t data_out
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                            state;
  tbba_pkg::job_t                        job;
  logic [3:0]                            step;
  logic [5:0]                            iter;
  logic signed [tbba_pkg::PROD_BITS-1:0] mreg;
  logic signed [tbba_pkg::PROD_BITS-1:0] tsave;
  logic signed [tbba_pkg::PROD_BITS-1:0] cdiff;
  logic [tbba_pkg::PROD_BITS-1:0]        cabs;
  logic [tbba_pkg::MAG_BITS-1:0]         c0, c1, c2, csel;
  logic signed [tbba_pkg::MUL_BITS-1:0]  op_a, op_b;
  logic [tbba_pkg::ACC_BITS-1:0]         acc;
  logic [tbba_pkg::ACC_BITS-1:0]         addend;
  logic [tbba_pkg::REM_BITS-1:0]         rem;
  logic [tbba_pkg::REM_BITS+1:0]         rem_sh;
  logic [tbba_pkg::REM_BITS+1:0]         trial;
  logic [tbba_pkg::ROOT_BITS-1:0]        root;
  tbba_pkg::area_t                       area_total;
  tbba_pkg::area_t                       area_base;
  logic [tbba_pkg::AREA_BITS:0]          area_sum;
  logic                                  out_valid;
  logic                                  out_load;

  assign empty = !out_valid;
  assign q_pop = (state == ST_IDLE) && !q_empty;
  assign out_load = (state == ST_DONE) && (!out_valid || pop);

  always_comb begin
    unique case (step)
      4'd6, 4'd7, 4'd8:    csel = c0;
      4'd9, 4'd10, 4'd11:  csel = c1;
      default:             csel = c2;
    endcase
  end

  always_comb begin
    unique case (step)
      4'd0: begin op_a = tbba_pkg::MUL_BITS'(job.ab_y); op_b = tbba_pkg::MUL_BITS'(job.ac_z); end
      4'd1: begin op_a = tbba_pkg::MUL_BITS'(job.ab_z); op_b = tbba_pkg::MUL_BITS'(job.ac_y); end
      4'd2: begin op_a = tbba_pkg::MUL_BITS'(job.ab_z); op_b = tbba_pkg::MUL_BITS'(job.ac_x); end
      4'd3: begin op_a = tbba_pkg::MUL_BITS'(job.ab_x); op_b = tbba_pkg::MUL_BITS'(job.ac_z); end
      4'd4: begin op_a = tbba_pkg::MUL_BITS'(job.ab_x); op_b = tbba_pkg::MUL_BITS'(job.ac_y); end
      4'd5: begin op_a = tbba_pkg::MUL_BITS'(job.ab_y); op_b = tbba_pkg::MUL_BITS'(job.ac_x); end
      4'd6, 4'd9, 4'd12: begin
        op_a = {1'b0, csel[tbba_pkg::MAG_BITS-1:tbba_pkg::HALF_BITS]};
        op_b = {1'b0, csel[tbba_pkg::MAG_BITS-1:tbba_pkg::HALF_BITS]};
      end
      4'd7, 4'd10, 4'd13: begin
        op_a = {1'b0, csel[tbba_pkg::MAG_BITS-1:tbba_pkg::HALF_BITS]};
        op_b = {1'b0, csel[tbba_pkg::HALF_BITS-1:0]};
      end
      4'd8, 4'd11, 4'd14: begin
        op_a = {1'b0, csel[tbba_pkg::HALF_BITS-1:0]};
        op_b = {1'b0, csel[tbba_pkg::HALF_BITS-1:0]};
      end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_comb begin
    cdiff = tsave - mreg;
    cabs  = cdiff[tbba_pkg::PROD_BITS-1] ? tbba_pkg::PROD_BITS'(-cdiff) : cdiff;
    unique case (step)
      4'd7, 4'd10, 4'd13: addend = tbba_pkg::ACC_BITS'(mreg) << (2 * tbba_pkg::HALF_BITS);
      4'd8, 4'd11, 4'd14: addend = tbba_pkg::ACC_BITS'(mreg) << tbba_pkg::HALF_BITS;
      4'd9, 4'd12, 4'd15: addend = tbba_pkg::ACC_BITS'(mreg);
      default:            addend = '0;
    endcase
    rem_sh    = {rem, acc[tbba_pkg::ACC_BITS-1:tbba_pkg::ACC_BITS-2]};
    trial     = (tbba_pkg::REM_BITS + 2)'({root, 2'b01});
    area_base = job.restart ? '0 : area_total;
    area_sum  = {1'b0, area_base} + (tbba_pkg::AREA_BITS + 1)'(root);
  end

  // hl term is 2*h*l at weight 2^HALF: shift by HALF+1
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job  <= q_job;
      acc  <= '0;
      rem  <= '0;
      root <= '0;
      iter <= '0;
    end
    if (state == ST_MUL) begin
      mreg <= op_a * op_b;
      unique case (step)
        4'd1, 4'd3, 4'd5: tsave <= mreg;
        4'd2:             c0 <= cabs[tbba_pkg::MAG_BITS-1:0];
        4'd4:             c1 <= cabs[tbba_pkg::MAG_BITS-1:0];
        4'd6:             c2 <= cabs[tbba_pkg::MAG_BITS-1:0];
        4'd8, 4'd11, 4'd14: acc <= acc + (addend << 1);
        default:          acc <= acc + addend;
      endcase
    end
    if (state == ST_ROOT) begin
      acc  <= acc << 2;
      iter <= iter + 1'b1;
      if (rem_sh >= trial) begin
        rem  <= tbba_pkg::REM_BITS'(rem_sh - trial);
        root <= {root[tbba_pkg::ROOT_BITS-2:0], 1'b1};
      end else begin
        rem  <= tbba_pkg::REM_BITS'(rem_sh);
        root <= {root[tbba_pkg::ROOT_BITS-2:0], 1'b0};
      end
    end
    if (out_load) begin
      data_out.min_x          <= job.min_x;
      data_out.min_y          <= job.min_y;
      data_out.min_z          <= job.min_z;
      data_out.max_x          <= job.max_x;
      data_out.max_y          <= job.max_y;
      data_out.max_z          <= job.max_z;
      data_out.area_sum       <= area_sum[tbba_pkg::AREA_BITS] ? '1 :
                                 area_sum[tbba_pkg::AREA_BITS-1:0];
      data_out.triangle_count <= job.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      out_valid  <= 1'b0;
      area_total <= '0;
    end else begin
      if (out_load) begin
        out_valid  <= 1'b1;
        area_total <= area_sum[tbba_pkg::AREA_BITS] ? '1 : area_sum[tbba_pkg::AREA_BITS-1:0];
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          step <= '0;
          if (!q_empty) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          step <= step + 1'b1;
          if (step == 4'(tbba_pkg::STEP_LAST)) begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (iter == 6'(tbba_pkg::ROOT_BITS - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/tbba_checker.sv =====
// ----------------------------------------------------------------------------
// tbba_checker
// Port-level checks for the triangle bbox/area accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangle_bbox_area_accumulator_assert.svh"

module tbba_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                full,
  input wire logic                empty,
  input wire logic                pop,
  input wire tbba_pkg::out_word_t data_out
);

  logic box_ok;

  assign box_ok = (data_out.min_x <= data_out.max_x) && (data_out.min_y <= data_out.max_y) &&
                  (data_out.min_z <= data_out.max_z);

  `TBBA_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, empty, "result shown after reset")
  `TBBA_ASSERT_NEXT(a_reset_full, clk, 1'b0, rst, !full, "full after reset")
  `TBBA_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(data_out), "dropped")
  `TBBA_ASSERT_IMP(a_count, clk, rst, !empty, data_out.triangle_count != '0, "zero count")
  `TBBA_ASSERT_IMP(a_box, clk, rst, !empty, box_ok, "box inverted")

endmodule

bind triangle_bbox_area_accumulator tbba_checker u_chk (.*);

`default_nettype wire

// ===== tb/sv/tb_triangle_bbox_area_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_bbox_area_accumulator
// Streams triangles into the bbox/area accumulator with bursty pushes and
// patterned pops. Every popped word is compared field by field against an
// in-bench model of the box, the floored doubled area and the saturating totals.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_triangle_bbox_area_accumulator;

  localparam int N_RANDOM = 1150;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  tbba_pkg::in_word_t data_in = '0;
  tbba_pkg::out_word_t data_out;

  triangle_bbox_area_accumulator DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .data_in(data_in),
    .empty(empty), .pop(pop), .data_out(data_out)
  );

  always #1 clk = ~clk;

  tbba_pkg::coord_t bmin [3];
  tbba_pkg::coord_t bmax [3];
  tbba_pkg::area_t area_acc;
  tbba_pkg::count_t tri_tally;
  tbba_pkg::out_word_t sums_q[$];
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int idle_cycles = 0;
  int meshes = 0;
  bit done_sending = 1'b0;

  function automatic logic [63:0] isqrt128(input logic [127:0] n);
    logic [127:0] r, t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= n) r = t;
    end
    return r[63:0];
  endfunction

  function automatic logic [127:0] cross_sq(input logic signed [63:0] p1, q1, p2, q2);
    logic signed [127:0] d;
    d = 128'(p1) * 128'(q1) - 128'(p2) * 128'(q2);
    if (d < 0) d = -d;
    return d * d;
  endfunction

  function automatic tbba_pkg::out_word_t mesh_update(input tbba_pkg::in_word_t w);
    tbba_pkg::coord_t v [9];
    logic signed [63:0] ab [3];
    logic signed [63:0] ac [3];
    logic [127:0] n;
    logic [63:0] tw;
    tbba_pkg::out_word_t o;
    v = '{w.ax, w.ay, w.az, w.bx, w.by, w.bz, w.cxin, w.cyin, w.czin};
    if (w.start_mesh) begin
      area_acc = '0;
      tri_tally = '0;
    end
    for (int k = 0; k < 3; k++)
      for (int c = 0; c < 3; c++) begin
        if (tri_tally == 0 && k == 0) begin
          bmin[c] = v[c];
          bmax[c] = v[c];
        end else begin
          if (v[3*k+c] < bmin[c]) bmin[c] = v[3*k+c];
          if (v[3*k+c] > bmax[c]) bmax[c] = v[3*k+c];
        end
      end
    for (int c = 0; c < 3; c++) begin
      ab[c] = 64'(v[3+c]) - 64'(v[c]);
      ac[c] = 64'(v[6+c]) - 64'(v[c]);
    end
    n = cross_sq(ab[1], ac[2], ab[2], ac[1]) + cross_sq(ab[2], ac[0], ab[0], ac[2])
      + cross_sq(ab[0], ac[1], ab[1], ac[0]);
    tw = isqrt128(n);
    area_acc = (area_acc > ~64'd0 - tw) ? ~64'd0 : area_acc + tw;
    if (tri_tally != ~tbba_pkg::count_t'(0)) tri_tally++;
    o.min_x = bmin[0]; o.min_y = bmin[1]; o.min_z = bmin[2];
    o.max_x = bmax[0]; o.max_y = bmax[1]; o.max_z = bmax[2];
    o.area_sum = area_acc;
    o.triangle_count = tri_tally;
    return o;
  endfunction

  function automatic tbba_pkg::coord_t rnd_coord(input int mode);
    case (mode)
      0: return tbba_pkg::coord_t'($urandom);
      1: return tbba_pkg::coord_t'($urandom_range(0, 4095)) - 2048;
      2: return ($urandom_range(0, 1)) ? 24'sh7fffff : -24'sh800000;
      default: return tbba_pkg::coord_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic tbba_pkg::in_word_t rnd_triangle();
    tbba_pkg::in_word_t w;
    int mode;
    mode = $urandom_range(0, 9);
    mode = (mode < 4) ? 0 : (mode < 8) ? 1 : (mode == 8) ? 2 : 3;
    w.ax = rnd_coord(mode); w.ay = rnd_coord(mode); w.az = rnd_coord(mode);
    w.bx = rnd_coord(mode); w.by = rnd_coord(mode); w.bz = rnd_coord(mode);
    w.cxin = rnd_coord(mode); w.cyin = rnd_coord(mode); w.czin = rnd_coord(mode);
    if ($urandom_range(0, 19) == 0) w.cxin = w.ax + (w.bx - w.ax);
    if ($urandom_range(0, 29) == 0) begin
      w.bx = w.ax; w.by = w.ay; w.bz = w.az;
    end
    w.start_mesh = ($urandom_range(0, 24) == 0);
    return w;
  endfunction

  localparam tbba_pkg::coord_t PMAX = 24'sh7fffff;
  localparam tbba_pkg::coord_t NMAX = -24'sh800000;
  typedef struct {
    tbba_pkg::in_word_t w;
    bit known;
    tbba_pkg::out_word_t exp_word;
  } row_t;
  row_t directed [$];

  function automatic tbba_pkg::in_word_t tri_word(input tbba_pkg::coord_t a0, a1, a2,
                                                  b0, b1, b2, c0, c1, c2,
                                                  input logic sm);
    tbba_pkg::in_word_t w;
    w = '{a0, a1, a2, b0, b1, b2, c0, c1, c2, sm};
    return w;
  endfunction

  function automatic void add_row(input tbba_pkg::in_word_t w, input bit known,
                                  input tbba_pkg::out_word_t exp_w);
    row_t r;
    r.w = w;
    r.known = known;
    r.exp_word = exp_w;
    directed.insert(directed.size(), r);
  endfunction

  initial begin
    tbba_pkg::out_word_t e;
    add_row(tri_word(256, 512, -256, 256, 512, -256, 256, 512, -256, 0), 1,
            '{256, 512, -256, 256, 512, -256, 64'd0, 32'd1});
    add_row(tri_word(0, 0, 0, 256, 0, 0, 0, 256, 0, 0), 0, '0);
    add_row(tri_word(NMAX, NMAX, NMAX, PMAX, NMAX, NMAX, NMAX, PMAX, NMAX, 1), 0, '0);
    add_row(tri_word(PMAX, PMAX, PMAX, NMAX, NMAX, PMAX, PMAX, NMAX, NMAX, 0), 0, '0);
    add_row(tri_word(NMAX, PMAX, NMAX, PMAX, NMAX, PMAX, NMAX, NMAX, PMAX, 0), 0, '0);
    add_row(tri_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1,
            '{0, 0, 0, 0, 0, 0, 64'd0, 32'd1});
    add_row(tri_word(-1, -1, -1, 1, 1, 1, 3, 3, 3, 0), 0, '0);
    add_row(tri_word(5, 6, 7, 5, 6, 7, 5, 6, 7, 1), 1,
            '{5, 6, 7, 5, 6, 7, 64'd0, 32'd1});
    add_row(tri_word(PMAX, 0, NMAX, NMAX, PMAX, 0, 0, NMAX, PMAX, 0), 0, '0);
    for (int i = 0; i < 6; i++)
      add_row(tri_word(NMAX, PMAX, NMAX, PMAX, NMAX, NMAX, PMAX, PMAX, PMAX, 0), 0, '0);
    add_row(tri_word(100, -100, 7, 90, 0, -3, -1000, 55, 9, 1), 0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      push <= 1'b1;
      data_in <= directed[i].w;
      e = mesh_update(directed[i].w);
      if (directed[i].known) begin
        if (e != directed[i].exp_word) begin
          $error("directed row %0d: table %p model %p", i, directed[i].exp_word, e);
          errors++;
        end
      end
      sums_q.insert(sums_q.size(), e);
      if (directed[i].w.start_mesh) meshes++;
      do @(posedge clk); while (full);
      push <= 1'b0;
      @(posedge clk);
    end

    for (int i = 0; i < N_RANDOM; ) begin
      int burst;
      int gap;
      tbba_pkg::in_word_t w;
      burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
      for (int j = 0; j < burst && i < N_RANDOM; j++, i++) begin
        w = rnd_triangle();
        push <= 1'b1;
        data_in <= w;
        sums_q.insert(sums_q.size(), mesh_update(w));
        if (w.start_mesh) meshes++;
        do @(posedge clk); while (full);
      end
      gap = $urandom_range(0, 120);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    push <= 1'b0;
    done_sending = 1'b1;
  end

  // Receiver: alternate between free running and patterned stalls.
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9]) pop <= 1'b1;
      else pop <= ($urandom_range(0, 3) != 0) && (stall_phase[2:0] != 3'd5);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) words_in <= words_in + 1;
      if (pop && !empty) begin
        tbba_pkg::out_word_t e;
        words_out <= words_out + 1;
        if (sums_q.size() == 0) begin
          $error("unexpected word %p", data_out);
          errors++;
        end else begin
          e = sums_q.pop_front();
          if (data_out.min_x !== e.min_x) begin
            $error("min_x exp %0d got %0d", e.min_x, data_out.min_x); errors++;
          end
          if (data_out.min_y !== e.min_y) begin
            $error("min_y exp %0d got %0d", e.min_y, data_out.min_y); errors++;
          end
          if (data_out.min_z !== e.min_z) begin
            $error("min_z exp %0d got %0d", e.min_z, data_out.min_z); errors++;
          end
          if (data_out.max_x !== e.max_x) begin
            $error("max_x exp %0d got %0d", e.max_x, data_out.max_x); errors++;
          end
          if (data_out.max_y !== e.max_y) begin
            $error("max_y exp %0d got %0d", e.max_y, data_out.max_y); errors++;
          end
          if (data_out.max_z !== e.max_z) begin
            $error("max_z exp %0d got %0d", e.max_z, data_out.max_z); errors++;
          end
          if (data_out.area_sum !== e.area_sum) begin
            $error("area_sum exp %0d got %0d", e.area_sum, data_out.area_sum); errors++;
          end
          if (data_out.triangle_count !== e.triangle_count) begin
            $error("triangle_count exp %0d got %0d", e.triangle_count,
                   data_out.triangle_count);
            errors++;
          end
        end
      end
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (!rst);
    fork
      begin
        wait (done_sending && sums_q.size() == 0);
        repeat (200) @(posedge clk);
      end
      wait (idle_cycles >= WATCHDOG);
    join_any
    if (idle_cycles >= WATCHDOG) begin
      $display("timeout: no word accepted for %0d cycles", WATCHDOG);
      $display("FAIL triangle_bbox_area_accumulator");
    end else begin
      $display("%0d triangles pushed, %0d result words checked, %0d meshes restarted",
               words_in, words_out, meshes);
      if (errors == 0 && sums_q.size() == 0)
        $display("PASS triangle_bbox_area_accumulator");
      else
        $display("FAIL triangle_bbox_area_accumulator");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/tbba_pkg.sv
sv/tbba_front.sv
sv/tbba_queue.sv
sv/tbba_back.sv
sv/triangle_bbox_area_accumulator.sv
sv/tbba_checker.sv
tb/sv/tb_triangle_bbox_area_accumulator.sv
